// ----- design/pva_pkg.sv -----
// pva_pkg: shared widths, defaults and request codes for the priority voice allocator
// no dependencies
package pva_pkg;

    localparam int VOICES_DEF = 8;

    localparam int KIND_W = 2;
    localparam int ID_W   = 16;
    localparam int PRIO_W = 16;
    localparam int SLOT_W = 3;

    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

endpackage

// ----- design/priority_voice_allocator_unit.sv -----
// priority_voice_allocator_unit: voice allocator over VOICES playback slots
// slot priorities and emitter ids live in two synchronous memories; the priority memory has one read and one write port
// depends on pva_pkg
//
// Usage: a request (i_kind, i_emitter_id, i_request_priority, i_slot_index) is
// taken at a rising edge with start high and busy low. Exactly one result per
// request appears on the o_ result ports for one cycle, marked by o_valid; the
// receiver cannot stall, so a result is never held back or repeated.
// Steps from the accepting edge to the result cycle:
//   start request : scan of the priority memory, one slot a cycle, then an
//                   emitter read and the write back
//   query request : the same scan, no write back
//   stop request  : read-modify-write of one priority entry
//   stop out of range or unused kind : no memory access, all-zero result
// The scan reads the priority memory one entry per cycle through its single
// read port. One request is worked on at a time; busy is low again in the
// result cycle, so the next request may be taken there.
// Reset clears every per-slot valid bit at once: an entry not yet written
// reads as free with priority zero, so no clearing pass is needed.
module priority_voice_allocator_unit #(
    parameter int VOICES = pva_pkg::VOICES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [pva_pkg::KIND_W-1:0] i_kind,
    input  logic [pva_pkg::ID_W-1:0]   i_emitter_id,
    input  logic [pva_pkg::PRIO_W-1:0] i_request_priority,
    input  logic [pva_pkg::SLOT_W-1:0] i_slot_index,
    output logic                      o_valid,
    output logic [pva_pkg::SLOT_W-1:0] o_chosen_slot,
    output logic                      o_evicted_valid,
    output logic [pva_pkg::ID_W-1:0]   o_evicted_emitter,
    output logic                      o_play_allowed
);

    localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PRIO_W = pva_pkg::PRIO_W;
    localparam int ID_W   = pva_pkg::ID_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_EMIT_RD,
        S_START_WR,
        S_STOP_RD,
        S_STOP_WR
    } t_state;

    t_state r_state;

    // priority memory word: {busy, priority}
    logic [PRIO_W:0]              r_slot_mem [VOICES];
    logic [ID_W-1:0]              r_emit_mem [VOICES];
    logic [VOICES-1:0]            r_slot_vld;

    logic [PRIO_W:0]              r_rd_word;
    logic                         r_rd_vld;
    logic                         r_rd_pend;
    logic [ID_W-1:0]              r_emit_q;

    logic [pva_pkg::KIND_W-1:0]   r_kind;
    logic [ID_W-1:0]              r_id;
    logic [PRIO_W-1:0]            r_prio;
    logic [IDX_W-1:0]             r_slot;
    logic [IDX_W-1:0]             r_cnt;

    logic [PRIO_W:0]              r_best;
    logic [IDX_W-1:0]             r_pick;
    logic                         r_best_busy;
    logic                         r_allowed;

    logic [PRIO_W:0]              n_best;
    logic [IDX_W-1:0]             n_pick;
    logic                         n_best_busy;
    logic                         n_allowed;

    logic [PRIO_W-1:0]            data_prio;
    logic                         data_busy;
    logic [IDX_W-1:0]             rd_addr;
    logic                         wr_en;
    logic [IDX_W-1:0]             wr_addr;
    logic [PRIO_W:0]              wr_data;
    logic                         emit_we;
    logic                         slot_in_range;

    assign busy          = (r_state != S_IDLE);
    assign data_prio     = r_rd_vld ? r_rd_word[PRIO_W-1:0] : '0;
    assign data_busy     = r_rd_vld & r_rd_word[PRIO_W];
    assign slot_in_range = (32'(i_slot_index) < 32'(VOICES));

    // scan step on the entry read in the previous cycle
    always_comb begin
        n_best      = r_best;
        n_pick      = r_pick;
        n_best_busy = r_best_busy;
        n_allowed   = r_allowed;
        if (r_rd_pend) begin
            if ({1'b0, data_prio} < r_best) begin
                n_best      = {1'b0, data_prio};
                n_pick      = r_cnt - IDX_W'(1);
                n_best_busy = data_busy;
            end
            if (!data_busy || (data_prio < r_prio)) begin
                n_allowed = 1'b1;
            end
        end
    end

    // memory port control
    always_comb begin
        rd_addr = r_cnt;
        wr_en   = 1'b0;
        wr_addr = r_pick;
        wr_data = {1'b1, r_prio};
        emit_we = 1'b0;
        unique case (r_state)
            S_STOP_RD: begin
                rd_addr = r_slot;
            end
            S_START_WR: begin
                wr_en   = 1'b1;
                emit_we = 1'b1;
            end
            S_STOP_WR: begin
                wr_en   = data_busy;
                wr_addr = r_slot;
                wr_data = {1'b0, data_prio};
            end
            default: begin
                rd_addr = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_mem[wr_addr] <= wr_data;
        end
        r_rd_word <= r_slot_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (emit_we) begin
            r_emit_mem[r_pick] <= r_id;
        end
        r_emit_q <= r_emit_mem[r_pick];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_slot_vld        <= '0;
            r_rd_vld          <= 1'b0;
            r_rd_pend         <= 1'b0;
            r_cnt             <= '0;
            r_best            <= '0;
            r_pick            <= '0;
            r_best_busy       <= 1'b0;
            r_allowed         <= 1'b0;
            o_valid           <= 1'b0;
            o_chosen_slot     <= '0;
            o_evicted_valid   <= 1'b0;
            o_evicted_emitter <= '0;
            o_play_allowed    <= 1'b0;
        end else begin
            o_valid           <= 1'b0;
            o_chosen_slot     <= '0;
            o_evicted_valid   <= 1'b0;
            o_evicted_emitter <= '0;
            o_play_allowed    <= 1'b0;
            r_rd_vld          <= r_slot_vld[rd_addr];
            r_rd_pend         <= 1'b0;
            if (wr_en) begin
                r_slot_vld[wr_addr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind      <= i_kind;
                        r_id        <= i_emitter_id;
                        r_prio      <= i_request_priority;
                        r_slot      <= IDX_W'(i_slot_index);
                        r_cnt       <= '0;
                        r_best      <= {1'b1, {PRIO_W{1'b0}}};
                        r_pick      <= '0;
                        r_best_busy <= 1'b0;
                        r_allowed   <= 1'b0;
                        if (i_kind == pva_pkg::KIND_START || i_kind == pva_pkg::KIND_QUERY) begin
                            r_state <= S_SCAN;
                        end else if (i_kind == pva_pkg::KIND_STOP && slot_in_range) begin
                            r_state <= S_STOP_RD;
                        end else begin
                            o_valid <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    r_best      <= n_best;
                    r_pick      <= n_pick;
                    r_best_busy <= n_best_busy;
                    r_allowed   <= n_allowed;
                    r_rd_pend   <= 1'b1;
                    r_cnt       <= r_cnt + IDX_W'(1);
                    if (r_cnt == IDX_W'(VOICES - 1)) begin
                        r_state <= S_SCAN_END;
                    end
                end
                S_SCAN_END: begin
                    r_best      <= n_best;
                    r_pick      <= n_pick;
                    r_best_busy <= n_best_busy;
                    r_allowed   <= n_allowed;
                    if (r_kind == pva_pkg::KIND_START) begin
                        r_state <= S_EMIT_RD;
                    end else begin
                        o_valid        <= 1'b1;
                        o_play_allowed <= n_allowed;
                        r_state        <= S_IDLE;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_START_WR;
                end
                S_START_WR: begin
                    o_valid           <= 1'b1;
                    o_chosen_slot     <= pva_pkg::SLOT_W'(r_pick);
                    o_evicted_valid   <= r_best_busy;
                    o_evicted_emitter <= r_best_busy ? r_emit_q : '0;
                    r_state           <= S_IDLE;
                end
                S_STOP_RD: begin
                    r_state <= S_STOP_WR;
                end
                S_STOP_WR: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/pva_checker.sv -----
// pva_checker: port-level checks on the voice allocator's request and result timing and result fields
// bound to priority_voice_allocator_unit; depends on pva_pkg
module pva_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [pva_pkg::SLOT_W-1:0] o_chosen_slot,
    input logic                       o_evicted_valid,
    input logic [pva_pkg::ID_W-1:0]   o_evicted_emitter,
    input logic                       o_play_allowed
);

    // result appears only once the request has finished
    a_result_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // an accepted request either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> (busy || o_valid))
        else $error("accepted request neither answered nor in progress");

    // result fields are quiet outside the strobe
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> (o_chosen_slot == '0 && !o_evicted_valid &&
                      o_evicted_emitter == '0 && !o_play_allowed))
        else $error("result fields driven without strobe");

    // a query answer and an eviction never share one result
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_play_allowed && o_evicted_valid))
        else $error("query answer and eviction in one result");

endmodule

bind priority_voice_allocator_unit pva_checker u_pva_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_chosen_slot     (o_chosen_slot),
    .o_evicted_valid   (o_evicted_valid),
    .o_evicted_emitter (o_evicted_emitter),
    .o_play_allowed    (o_play_allowed)
);
